[sv/bdrd_pkg.sv]
// shared types, constants and calendar helpers for the business day return date block
`timescale 1ns / 1ps
`default_nettype none

package bdrd_pkg;

    localparam int COUNT_BITS = 12;
    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 14;
    localparam int WDAY_W     = 3;
    localparam int VAC_W      = 12;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;
    localparam int STATUS_W   = 2;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [DAY_W-1:0]      day_t;
    typedef logic [MONTH_W-1:0]    month_t;
    typedef logic [YEAR_W-1:0]     year_t;
    typedef logic [WDAY_W-1:0]     wday_t;

    localparam year_t  YEAR_MAX  = 14'd9999;
    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_DEC = 4'd12;
    localparam day_t   DAY_LAST  = 5'd31;
    localparam wday_t  WD_SUN    = 3'd0;
    localparam wday_t  WD_FRI    = 3'd5;
    localparam wday_t  WD_SAT    = 3'd6;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_DATE = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SKIP_A,
        ST_WALK,
        ST_SKIP_B,
        ST_DONE
    } state_t;

    // date packed with the day in the lowest bits
    typedef struct packed {
        year_t  year;
        month_t month;
        day_t   day;
    } date_t;

    // result of the start date analysis
    typedef struct packed {
        logic        valid;
        wday_t       wday;
        logic        leap;
        logic [1:0]  rem4;
        logic [6:0]  rem100;
        logic [1:0]  cent4;
    } prep_res_t;

    // leap year from year mod 4, year mod 100 and century mod 4
    function automatic logic leap_of(logic [1:0] rem4, logic [6:0] rem100, logic [1:0] cent4);
        logic l;
        if (rem100 == 7'd0) begin
            l = (cent4 == 2'd0);
        end else begin
            l = (rem4 == 2'd0);
        end
        return l;
    endfunction

    function automatic day_t month_len(month_t m, logic leap);
        day_t len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic is_weekend(wday_t w);
        return (w == WD_FRI) || (w == WD_SAT);
    endfunction

endpackage

`default_nettype wire

[sv/bdrd_prep.sv]
// start date analysis: validity, leap residues and weekday, computed step by step on one multiplier
`timescale 1ns / 1ps
`default_nettype none

module bdrd_prep (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire bdrd_pkg::date_t    date_in,
    output logic                    done,
    output bdrd_pkg::prep_res_t     res
);
    import bdrd_pkg::*;

    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int QUOT_W      = 8;
    localparam int SUM_W       = 15;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    localparam logic [2:0] STEP_Q_Y   = 3'd0;
    localparam logic [2:0] STEP_Q_YY  = 3'd1;
    localparam logic [2:0] STEP_Q_YY4 = 3'd2;
    localparam logic [2:0] STEP_CHECK = 3'd3;
    localparam logic [2:0] STEP_FOLD  = 3'd4;

    // floor(31 * mm / 12) for the shifted month
    function automatic logic [4:0] month_offset(month_t mm);
        logic [4:0] o;
        case (mm)
            4'd1:    o = 5'd2;
            4'd2:    o = 5'd5;
            4'd3:    o = 5'd7;
            4'd4:    o = 5'd10;
            4'd5:    o = 5'd12;
            4'd6:    o = 5'd15;
            4'd7:    o = 5'd18;
            4'd8:    o = 5'd20;
            4'd9:    o = 5'd23;
            4'd10:   o = 5'd25;
            4'd11:   o = 5'd28;
            4'd12:   o = 5'd31;
            default: o = 5'd0;
        endcase
        return o;
    endfunction

    function automatic year_t times100(logic [QUOT_W-1:0] q);
        year_t qe;
        qe = YEAR_W'(q);
        return (qe << 6) + (qe << 5) + (qe << 2);
    endfunction

    logic               run_reg, run_next;
    logic [2:0]         step_reg, step_next;
    logic               done_reg, done_next;
    logic [QUOT_W-1:0]  q_y_reg, q_yy_reg, q_yy4_reg;
    logic [SUM_W-1:0]   sum_reg;
    prep_res_t          res_reg, res_next;

    logic               early_month;
    year_t              yy;
    month_t             mm;
    year_t              mul_op;
    logic [PROD_W-1:0]  product;
    logic [QUOT_W-1:0]  quot;
    year_t              rem100_full;
    logic [6:0]         rem100;
    logic               leap;
    day_t               mlen;
    logic               valid;
    logic [SUM_W-1:0]   sum;
    logic [5:0]         fold1;
    logic [3:0]         fold2;
    wday_t              wday;

    // january and february count as months of the previous year
    assign early_month = (date_in.month == MONTH_JAN) || (date_in.month == MONTH_FEB);
    assign yy          = date_in.year - YEAR_W'(early_month);
    assign mm          = early_month ? (date_in.month + 4'd10) : (date_in.month - 4'd2);

    // shared reciprocal multiplier, divide by 100
    always_comb begin
        case (step_reg)
            STEP_Q_Y:  mul_op = date_in.year;
            STEP_Q_YY: mul_op = yy;
            default:   mul_op = yy >> 2;
        endcase
    end

    assign product = PROD_W'(mul_op) * PROD_W'(RECIP_100);
    assign quot    = product[RECIP_SHIFT +: QUOT_W];

    assign rem100_full = date_in.year - times100(q_y_reg);
    assign rem100      = rem100_full[6:0];
    assign leap        = leap_of(date_in.year[1:0], rem100, q_y_reg[1:0]);
    assign mlen        = month_len(date_in.month, leap);
    assign valid       = (date_in.month >= MONTH_JAN) && (date_in.month <= MONTH_DEC)
                       && (date_in.year != '0) && (date_in.year <= YEAR_MAX)
                       && (date_in.day != '0) && (date_in.day <= mlen);

    assign sum = SUM_W'(date_in.day) + SUM_W'(yy) + SUM_W'(yy >> 2) - SUM_W'(q_yy_reg)
               + SUM_W'(q_yy4_reg) + SUM_W'(month_offset(mm));

    // mod 7 by summing octal digits, since 8 is 1 mod 7
    assign fold1 = 6'(sum_reg[2:0]) + 6'(sum_reg[5:3]) + 6'(sum_reg[8:6])
                 + 6'(sum_reg[11:9]) + 6'(sum_reg[14:12]);
    assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    assign wday  = (fold2 >= 4'd7) ? WDAY_W'(fold2 - 4'd7) : WDAY_W'(fold2);

    always_comb begin
        run_next  = run_reg;
        step_next = step_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start) begin
            run_next  = 1'b1;
            step_next = STEP_Q_Y;
        end else if (run_reg) begin
            step_next = step_reg + 3'd1;
            if (step_reg == STEP_CHECK) begin
                res_next.valid  = valid;
                res_next.leap   = leap;
                res_next.rem4   = date_in.year[1:0];
                res_next.rem100 = rem100;
                res_next.cent4  = q_y_reg[1:0];
            end
            if (step_reg == STEP_FOLD) begin
                res_next.wday = wday;
                run_next      = 1'b0;
                done_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            step_reg <= STEP_Q_Y;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (run_reg && step_reg == STEP_Q_Y) begin
            q_y_reg <= quot;
        end
        if (run_reg && step_reg == STEP_Q_YY) begin
            q_yy_reg <= quot;
        end
        if (run_reg && step_reg == STEP_Q_YY4) begin
            q_yy4_reg <= quot;
        end
        if (run_reg && step_reg == STEP_CHECK) begin
            sum_reg <= sum;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

[sv/bdrd_stepper.sv]
// calendar day stepper: holds the walked date and advances it one day per cycle while advance is high
`timescale 1ns / 1ps
`default_nettype none

module bdrd_stepper (
    input  wire logic                aclk,
    input  wire logic                load,
    input  wire bdrd_pkg::date_t     load_date,
    input  wire bdrd_pkg::prep_res_t load_res,
    input  wire logic                advance,
    output bdrd_pkg::date_t          cur_date,
    output logic                     at_end,
    output logic                     weekend
);
    import bdrd_pkg::*;

    date_t       date_reg, date_next;
    wday_t       wday_reg, wday_next;
    logic        leap_reg, leap_next;
    logic [1:0]  rem4_reg, rem4_next;
    logic [6:0]  rem100_reg, rem100_next;
    logic [1:0]  cent4_reg, cent4_next;

    logic        month_end;

    assign month_end = date_reg.day >= month_len(date_reg.month, leap_reg);
    assign at_end    = month_end && (date_reg.month == MONTH_DEC) && (date_reg.year >= YEAR_MAX);
    assign weekend   = is_weekend(wday_reg);

    always_comb begin
        date_next   = date_reg;
        wday_next   = wday_reg;
        leap_next   = leap_reg;
        rem4_next   = rem4_reg;
        rem100_next = rem100_reg;
        cent4_next  = cent4_reg;
        if (load) begin
            date_next   = load_date;
            wday_next   = load_res.wday;
            leap_next   = load_res.leap;
            rem4_next   = load_res.rem4;
            rem100_next = load_res.rem100;
            cent4_next  = load_res.cent4;
        end else if (advance) begin
            wday_next = (wday_reg == WD_SAT) ? WD_SUN : wday_reg + 3'd1;
            if (month_end) begin
                date_next.day = 5'd1;
                if (date_reg.month == MONTH_DEC) begin
                    date_next.month = MONTH_JAN;
                    date_next.year  = date_reg.year + 14'd1;
                    rem4_next       = rem4_reg + 2'd1;
                    if (rem100_reg == 7'd99) begin
                        rem100_next = 7'd0;
                        cent4_next  = cent4_reg + 2'd1;
                    end else begin
                        rem100_next = rem100_reg + 7'd1;
                    end
                    leap_next = leap_of(rem4_next, rem100_next, cent4_next);
                end else begin
                    date_next.month = date_reg.month + 4'd1;
                end
            end else begin
                date_next.day = date_reg.day + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        date_reg   <= date_next;
        wday_reg   <= wday_next;
        leap_reg   <= leap_next;
        rem4_reg   <= rem4_next;
        rem100_reg <= rem100_next;
        cent4_reg  <= cent4_next;
    end

    assign cur_date = date_reg;

endmodule

`default_nettype wire

[sv/business_day_return_date.sv]
// top level of the business day return date block: sequencer, stream ports and result register
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | beat contents
// ----------+-----+-----------------------------------------------------------
// s_ (in)   | in  | start_day, start_month, start_year, vacation_days
// m_ (out)  | out | ret_day, ret_month, ret_year in tdata; status in tuser
//
// one beat in gives one beat out; the day stepper advances the date by one day
// per cycle through the walk (weekend skips and business days alike), and no
// new beat is taken until the result is loaded into the output register
// an invalid start date skips the walk and goes straight to the result
// reset (aresetn low, synchronous) returns the sequencer to idle and drops m_tvalid
// a result waiting on m_tready holds the sequencer in its last state; the next
// input beat is taken as soon as that result sits in the output register

module business_day_return_date (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // start_day [4:0], start_month [8:5], start_year [22:9], vacation_days [34:23]
    input  wire logic [bdrd_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // ret_day [4:0], ret_month [8:5], ret_year [22:9]
    output logic [bdrd_pkg::OUT_DATA_W-1:0]        m_tdata,
    // status [1:0]
    output logic [bdrd_pkg::STATUS_W-1:0]          m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready
);
    import bdrd_pkg::*;

    localparam date_t OVERFLOW_DATE = '{year: YEAR_MAX, month: MONTH_DEC, day: DAY_LAST};

    state_t    state_reg, state_next;
    date_t     in_date_reg;
    count_t    days_left_reg;
    status_t   status_reg, status_next;
    logic      m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [STATUS_W-1:0]   m_user_reg;

    // control between sequencer and units
    logic      accept;
    logic      prep_start;
    logic      prep_done;
    prep_res_t prep_res;
    logic      cal_load;
    logic      cal_advance;
    logic      days_dec;
    logic      out_load;
    date_t     cal_date;
    logic      cal_at_end;
    logic      cal_weekend;
    logic      out_free;
    date_t     out_date;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    bdrd_prep u_prep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (prep_start),
        .date_in (in_date_reg),
        .done    (prep_done),
        .res     (prep_res)
    );

    bdrd_stepper u_stepper (
        .aclk      (aclk),
        .load      (cal_load),
        .load_date (in_date_reg),
        .load_res  (prep_res),
        .advance   (cal_advance),
        .cur_date  (cal_date),
        .at_end    (cal_at_end),
        .weekend   (cal_weekend)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (prep_done) begin
                    state_next = prep_res.valid ? ST_SKIP_A : ST_DONE;
                end
            end
            ST_SKIP_A: begin
                if (!cal_weekend) begin
                    state_next = ST_WALK;
                end else if (cal_at_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK: begin
                if (days_left_reg == '0) begin
                    state_next = ST_SKIP_B;
                end else if (cal_at_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_SKIP_B: begin
                if (!cal_weekend || cal_at_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        prep_start  = 1'b0;
        cal_load    = 1'b0;
        cal_advance = 1'b0;
        days_dec    = 1'b0;
        out_load    = 1'b0;
        status_next = status_reg;
        unique case (state_reg) inside
            ST_IDLE: begin
                prep_start = accept;
            end
            ST_PREP: begin
                if (prep_done) begin
                    cal_load    = prep_res.valid;
                    status_next = prep_res.valid ? STATUS_OK : STATUS_BAD_DATE;
                end
            end
            ST_SKIP_A, ST_SKIP_B: begin
                if (cal_weekend) begin
                    cal_advance = !cal_at_end;
                    if (cal_at_end) begin
                        status_next = STATUS_OVERFLOW;
                    end
                end
            end
            ST_WALK: begin
                if (days_left_reg != '0) begin
                    cal_advance = !cal_at_end;
                    days_dec    = !cal_weekend;
                    if (cal_at_end) begin
                        status_next = STATUS_OVERFLOW;
                    end
                end
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // result date by outcome
    always_comb begin
        case (status_reg)
            STATUS_OK:       out_date = cal_date;
            STATUS_OVERFLOW: out_date = OVERFLOW_DATE;
            default:         out_date = in_date_reg;
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (accept) begin
            in_date_reg.day   <= s_tdata[4:0];
            in_date_reg.month <= s_tdata[8:5];
            in_date_reg.year  <= s_tdata[22:9];
            days_left_reg     <= COUNT_BITS'(s_tdata[34:23]);
        end else if (days_dec) begin
            days_left_reg <= days_left_reg - COUNT_BITS'(1);
        end
        if (out_load) begin
            m_data_reg <= OUT_DATA_W'(out_date);
            m_user_reg <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // a business day stepped over counts down the remaining days by one
    a_days_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && days_left_reg != '0 && !cal_weekend && !cal_at_end)
        |=> days_left_reg == $past(days_left_reg) - COUNT_BITS'(1))
        else $error("remaining business days not decremented");

    // the final weekend skip only starts once every business day is passed
    a_skip_b_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SKIP_B) |-> days_left_reg == '0)
        else $error("final weekend skip with business days left");

    // the stepper is never asked to go past the last representable day
    a_no_step_past_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_advance |-> !cal_at_end)
        else $error("day step requested past the last date");

    // a good result carries a plausible date
    a_ok_date: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_OK)
        |-> (m_tdata[4:0] != 5'd0 && m_tdata[8:5] >= MONTH_JAN && m_tdata[8:5] <= MONTH_DEC))
        else $error("good result with an impossible date");

endmodule

`default_nettype wire

[tb/business_day_return_date_test.sv]
// self-checking stream testbench for the business day return date block
`timescale 1ns / 1ps

module business_day_return_date_test;
    import bdrd_pkg::*;

    // clock, reset and run bounds
    localparam int CLK_HIGH      = 4;
    localparam int CLK_LOW       = 4;
    localparam int RESET_CYCLES  = 6;
    // slowest correct run: 103 beats, some with long walks, plus long stalls and
    // gaps; the limit leaves a wide margin over it
    localparam int CYCLE_LIMIT   = 2_500_000;
    // longer than one start date takes through the block with a walk of no days
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int BEATS_PER_PHASE = 20;

    // one return date as it leaves the block
    typedef struct {
        day_t    day;
        month_t  month;
        year_t   year;
        status_t status;
    } return_date_t;

    // every input is known from time zero
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    // idling percentages for the current phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // return dates still owed by the block, oldest first
    return_date_t expected_returns[$];

    int mismatch_count  = 0;
    int returns_checked = 0;
    int dates_sent      = 0;
    int bad_dates_sent  = 0;
    int overflows_sent  = 0;
    int cycle_count     = 0;

    business_day_return_date uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 8 ns clock
    always begin
        #CLK_HIGH aclk = 1'b1;
        #CLK_LOW  aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // calendar arithmetic of the predictor
    // ---------------------------------------------------------------------

    // gregorian rule: every 4th year, but not centuries unless divisible by 400
    function automatic bit is_leap_year(int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int days_in_month(int y, int m);
        int n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            2:                     n = is_leap_year(y) ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    // day of week, 0 is sunday; january and february count as months 11 and
    // 12 of the year before
    function automatic int day_of_week(int y, int m, int d);
        int a;
        int yy;
        int mm;
        a  = (14 - m) / 12;
        yy = y - a;
        mm = m + 12 * a - 2;
        return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    // return date for one start date and count of business days
    function automatic return_date_t predict_return_date(day_t d, month_t m, year_t y,
                                                         count_t n);
        return_date_t r;
        int  day;
        int  month;
        int  year;
        int  wday;
        int  days_left;
        bit  weekend;
        bit  overflow;
        if (m < MONTH_JAN || m > MONTH_DEC || y < 1 || y > YEAR_MAX ||
            d < 1 || d > days_in_month(y, m)) begin
            // bad start date is echoed back untouched
            r = '{d, m, y, STATUS_BAD_DATE};
            return r;
        end
        day       = d;
        month     = m;
        year      = y;
        wday      = day_of_week(y, m, d);
        days_left = n;
        overflow  = 1'b0;
        // leading weekend skip, the business day walk and the trailing skip
        // fold into one loop: weekend days are stepped over without counting
        forever begin
            weekend = (wday == WD_FRI) || (wday == WD_SAT);
            if (!weekend && days_left == 0) break;
            if (!weekend) days_left--;
            if (day >= days_in_month(year, month)) begin
                if (month == MONTH_DEC) begin
                    if (year >= YEAR_MAX) begin
                        overflow = 1'b1;
                        break;
                    end
                    day   = 1;
                    month = MONTH_JAN;
                    year++;
                end else begin
                    day = 1;
                    month++;
                end
            end else begin
                day++;
            end
            wday = (wday + 1) % 7;
        end
        if (overflow) begin
            r = '{DAY_LAST, MONTH_DEC, YEAR_MAX, STATUS_OVERFLOW};
        end else begin
            r = '{day_t'(day), month_t'(month), year_t'(year), STATUS_OK};
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // input side: one start date per beat
    // ---------------------------------------------------------------------

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_date(input day_t d, input month_t m, input year_t y, input count_t n);
        return_date_t         want;
        logic [IN_DATA_W-1:0] beat;
        // random gaps before the beat
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        beat     = '0;
        beat     = IN_DATA_W'({n, y, m, d});
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        // beat taken at this edge
        want = predict_return_date(d, m, y, n);
        expected_returns.push_back(want);
        dates_sent++;
        if (want.status == STATUS_BAD_DATE) bad_dates_sent++;
        if (want.status == STATUS_OVERFLOW) overflows_sent++;
        @(negedge aclk);
    endtask

    // drop tvalid and let every owed return date come back
    task automatic drain_returns();
        s_tvalid <= 1'b0;
        while (expected_returns.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // ---------------------------------------------------------------------
    // output side: receiver stalls and result checking
    // ---------------------------------------------------------------------

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic void report_mismatch(string what, return_date_t want,
                                            return_date_t got);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] %s: expected %0d/%0d/%0d status %s, got %0d/%0d/%0d status %0d",
                     $realtime, what, want.day, want.month, want.year, want.status.name(),
                     got.day, got.month, got.year, got.status);
        end
        mismatch_count++;
    endfunction

    function automatic void check_return_beat(logic [OUT_DATA_W-1:0] data,
                                              logic [STATUS_W-1:0] user);
        return_date_t got;
        return_date_t want;
        got.day    = data[DAY_W-1:0];
        got.month  = data[DAY_W+MONTH_W-1:DAY_W];
        got.year   = data[DAY_W+MONTH_W+YEAR_W-1:DAY_W+MONTH_W];
        got.status = status_t'(user);
        if (expected_returns.size() == 0) begin
            want = '{'0, '0, '0, STATUS_OK};
            report_mismatch("return beat with nothing owed", want, got);
        end else begin
            want = expected_returns.pop_front();
            returns_checked++;
            if (got.day !== want.day || got.month !== want.month ||
                got.year !== want.year || got.status !== want.status) begin
                report_mismatch("return date mismatch", want, got);
            end
        end
    endfunction

    // outputs sampled at the rising edge, before the block's own updates land
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_return_beat(m_tdata, m_tuser);
        end
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // field extremes, month and year rollover, leap rules, weekend starts
    task automatic test_calendar_edges();
        send_date(5'd1,  4'd1,  14'd1,    12'd0);     // earliest date
        send_date(5'd31, 4'd12, 14'd9998, 12'd3);     // year rollover
        send_date(5'd28, 4'd2,  14'd1900, 12'd1);     // century, not leap
        send_date(5'd28, 4'd2,  14'd2000, 12'd1);     // divisible by 400, leap
        send_date(5'd29, 4'd2,  14'd2024, 12'd0);     // leap day itself
        send_date(5'd15, 4'd6,  14'd2023, 12'd4095);  // longest count
        send_date(5'd10, 4'd3,  14'd5000, 12'd2048);  // top count bit alone
        send_date(5'd1,  4'd3,  14'd2024, 12'd0);     // friday, weekend skip only
        send_date(5'd2,  4'd3,  14'd2024, 12'd5);     // saturday start
        drain_returns();
    endtask

    // start dates that must be echoed with the bad date status
    task automatic test_invalid_dates();
        send_date(5'd0,  4'd1,  14'd2020,  12'd7);    // day zero
        send_date(5'd31, 4'd4,  14'd2021,  12'd1);    // past end of a 30 day month
        send_date(5'd29, 4'd2,  14'd2023,  12'd1);    // leap day in a common year
        send_date(5'd30, 4'd2,  14'd2000,  12'd1);    // beyond a leap february
        send_date(5'd31, 4'd0,  14'd2020,  12'd1);    // month zero
        send_date(5'd1,  4'd13, 14'd2020,  12'd1);    // month thirteen
        send_date(5'd5,  4'd15, 14'd2020,  12'd1);    // month field all ones
        send_date(5'd1,  4'd1,  14'd0,     12'd1);    // year zero
        send_date(5'd1,  4'd1,  14'd10000, 12'd1);    // just past the last year
        send_date(5'd31, 4'd15, 14'd16383, 12'd4095); // every field all ones
        drain_returns();
    endtask

    // walks that run off the end of year 9999 and ones that just stay inside
    task automatic test_year_overflow();
        send_date(5'd31, 4'd12, 14'd9999, 12'd0);     // last day is a friday
        send_date(5'd20, 4'd12, 14'd9999, 12'd4095);  // long walk off the end
        send_date(5'd29, 4'd12, 14'd9999, 12'd1);     // lands on the thursday before
        send_date(5'd30, 4'd12, 14'd9999, 12'd1);     // steps onto the last friday
        drain_returns();
    endtask

    // mostly valid dates with short counts, some long walks, some dates near the
    // end of the calendar and some raw noise across every field bit
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int     kind;
        int     y;
        int     m;
        int     d;
        count_t n;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < BEATS_PER_PHASE; i++) begin
            kind = $urandom_range(0, 99);
            m    = $urandom_range(MONTH_JAN, MONTH_DEC);
            y    = $urandom_range(1, YEAR_MAX);
            n    = count_t'($urandom_range(0, 40));
            if (kind < 10) begin
                // raw fields, valid or not
                d = $urandom_range(0, 31);
                m = $urandom_range(0, 15);
                y = $urandom_range(0, 16383);
                n = count_t'($urandom());
            end else begin
                if (kind < 16) begin
                    y = $urandom_range(YEAR_MAX - 9, YEAR_MAX);
                    n = count_t'($urandom_range(0, 600));
                end else if (kind < 21) begin
                    n = count_t'($urandom_range(0, 4095));
                end
                d = $urandom_range(1, days_in_month(y, m));
            end
            send_date(day_t'(d), month_t'(m), year_t'(y), n);
        end
        drain_returns();
    endtask

    // ---------------------------------------------------------------------
    // run sequence
    // ---------------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_calendar_edges();
        test_invalid_dates();
        test_year_overflow();
        test_random_traffic(0, 0);     // back to back
        test_random_traffic(83, 0);    // sparse sender
        test_random_traffic(0, 83);    // slow receiver
        test_random_traffic(12, 12);   // light gaps on both sides

        // anything still in flight would show up here as an unowed beat
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("sent %0d start dates (%0d invalid, %0d running past year 9999), checked %0d",
                 dates_sent, bad_dates_sent, overflows_sent, returns_checked);
        $display("traffic ran without gaps, with a sparse sender, a slow receiver and both");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d return dates still owed",
                 cycle_count, expected_returns.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
sv/bdrd_pkg.sv
sv/bdrd_prep.sv
sv/bdrd_stepper.sv
sv/business_day_return_date.sv
tb/business_day_return_date_test.sv
